>>> rtl/core/tcp_sender_window_retransmit_macros.svh
// Assertion helpers shared by the sender engine.
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_MACROS_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSWR_CHK_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSWR_CHK_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tswr_pkg.sv
`default_nettype none

package tswr_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int QUEUE_DEPTH = 128;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_EMPTY = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ISN     = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_PUSH_EVAL,
    S_PUSH_BRT,
    S_PUSH_NXT,
    S_EMPTY,
    S_ACK_OFF,
    S_ACK_UNW,
    S_ACK_HI,
    S_ACK_LIM,
    S_ACK_CHK,
    S_ACK_NEW,
    S_ACK_START,
    S_ACK_DIST,
    S_POP_RD,
    S_POP_CHK,
    S_ACK_END,
    S_TICK_ADD,
    S_TICK_CMP,
    S_STATUS,
    S_EMIT_RD,
    S_EMIT_LD,
    S_OUT
  } state_t;

  // Operation handed to the shared adder.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_op_t;

endpackage

`default_nettype wire

>>> rtl/core/tcp_sender_window_retransmit.sv
// TCP sender control engine: produces segment descriptors, not payload bytes.
// Requests enter on in_valid/in_ready with an opcode: push, receive ack, timer
// tick or empty message. Configuration writes (initial seqno, initial timeout)
// use cfg_valid/cfg_ready and are always accepted; write them while idle.
// Each request yields one or more results on out_valid/out_ready; the final
// one carries last_result. A request sending nothing yields one status result.
// One request is handled at a time: in_ready is high only while idle.
// Sequence, position and timer sums go through one shared 64-bit adder, one operation a cycle.
// Push: each segment sent is queued, then the byte position and next seqno
// advance; the results are then read back from the queue and delivered.
// Ack: the ackno is unwrapped and checked; new data acknowledged retires whole
// segments from the queue. Tick: elapsed time is added and tested for expiry.
// Each result waits in the output register until out_ready; a stalled
// receiver holds the engine. Reset empties the queue, clears the counters,
// sets the window to one and the timeout to its reset value.
`default_nettype none

`include "tcp_sender_window_retransmit_macros.svh"

module tcp_sender_window_retransmit #(
  parameter int MAX_PAYLOAD = tswr_pkg::MAX_PAYLOAD,
  parameter int QUEUE_DEPTH = tswr_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] bytes_available,
  input  wire logic        stream_closed,
  input  wire logic        stream_error,
  input  wire logic [31:0] ack_seqno,
  input  wire logic [15:0] ack_window,
  input  wire logic        ack_reset,
  input  wire logic [31:0] elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             segment_valid,
  output logic [31:0]      segment_seqno,
  output logic [10:0]      payload_length,
  output logic             syn_flag,
  output logic             fin_flag,
  output logic             rst_flag,
  output logic             is_retransmit,
  output logic             last_result,
  output logic [16:0]      in_flight,
  output logic [15:0]      retransmit_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
  localparam int QA_W    = $clog2(QUEUE_DEPTH);
  localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 32 + LEN_W + 3;
  localparam int RES_W   = tswr_pkg::RES_W;

  tswr_pkg::state_t state, state_next;

  // Configuration and connection state.
  logic [31:0] isn, init_timeout;
  logic [63:0] next_abs, acked_abs, brt;
  logic [15:0] peer_window;
  logic [16:0] fs;
  logic        timer_running;
  logic [31:0] timer_elapsed, cur_timeout;
  logic [15:0] retx_counter;
  logic        fin_done, error_latched;
  logic [QA_W-1:0] head, tail;
  logic [QC_W-1:0] ring_count;

  // Per-request working registers.
  logic [31:0] p_avail, p_consumed, ack_q, ms_q, off;
  logic        p_closed, p_err, p_last, adj_dec, adj_inc;
  logic [RES_W-1:0] p_n, em_left;
  logic [QA_W-1:0]  em_ptr;
  logic             em_retx;
  logic [16:0]      cur_take, cur_sl;
  logic [63:0]      abs_ack, lim, ack_dist;

  // Output register.
  logic        o_valid_seg, o_syn, o_fin, o_rst, o_retx, o_last;
  logic [31:0] o_seq;
  logic [10:0] o_len;

  // Shared adder.
  tswr_pkg::alu_op_t alu_op;
  logic [63:0] alu_sum;
  logic        alu_carry;

  tswr_alu u_alu (.op(alu_op), .sum(alu_sum), .carry(alu_carry));

  // Segment queue.
  logic               ram_we;
  logic [QA_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  tswr_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk(clk), .we(ram_we), .waddr(tail), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] p);
    ptr_inc = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Fields of the entry read from the queue.
  logic [31:0]      rd_seq;
  logic [LEN_W-1:0] rd_len;
  logic             rd_syn, rd_fin, rd_rst;
  logic [16:0]      rd_sl;

  always_comb begin
    rd_seq = ram_rdata[ENTRY_W-1 -: 32];
    rd_len = ram_rdata[LEN_W+2:3];
    rd_syn = ram_rdata[2];
    rd_fin = ram_rdata[1];
    rd_rst = ram_rdata[0];
    rd_sl  = 17'(rd_len) + 17'(rd_syn) + 17'(rd_fin);
  end

  // Segment cut for the next push step.
  logic [16:0] rem0, rem1, rem2, take, seg_sl;
  logic [31:0] buffered;
  logic        seg_syn, seg_fin, seg_last, push_stop;

  always_comb begin
    if (peer_window == '0 && fs == '0) begin
      rem0 = 17'd1;
    end else if (fs < {1'b0, peer_window}) begin
      rem0 = {1'b0, peer_window} - fs;
    end else begin
      rem0 = '0;
    end
    seg_syn  = (next_abs == '0);
    rem1     = rem0 - 17'(seg_syn);
    buffered = p_avail - p_consumed;
    take     = (buffered < 32'(rem1)) ? buffered[16:0] : rem1;
    seg_last = (take < 17'(MAX_PAYLOAD));
    if (!seg_last) begin
      take = 17'(MAX_PAYLOAD);
    end
    rem2     = rem1 - take;
    seg_fin  = p_closed && (buffered == 32'(take)) && (rem2 != '0);
    seg_sl   = take + 17'(seg_syn) + 17'(seg_fin);
    push_stop = p_last || (p_n >= RES_W'(tswr_pkg::MAX_RESULTS)) ||
                (ring_count >= QC_W'(QUEUE_DEPTH)) || (rem0 == '0) || fin_done ||
                (seg_sl == '0);
    ram_wdata = {alu_sum[31:0], LEN_W'(take), seg_syn, seg_fin, p_err};
  end

  // Unwrap decision from the low-half distance to the checkpoint.
  logic unw_dec, unw_inc;

  always_comb begin
    unw_dec = alu_carry && alu_sum[31] && (alu_sum[30:0] != '0) && (brt[63:32] != '0);
    unw_inc = !alu_carry && !alu_sum[31];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tswr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, adder operands and handshakes.
  always_comb begin
    state_next = state;
    alu_op     = '{a: next_abs, b: {32'b0, isn}, sub: 1'b0};
    ram_we     = 1'b0;
    ram_raddr  = em_ptr;
    in_ready   = (state == tswr_pkg::S_IDLE);
    out_valid  = (state == tswr_pkg::S_OUT);
    cfg_ready  = 1'b1;
    unique case (state)
      tswr_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (tswr_pkg::opcode_t'(opcode))
            tswr_pkg::OP_PUSH:  state_next = tswr_pkg::S_PUSH_EVAL;
            tswr_pkg::OP_ACK:   state_next = tswr_pkg::S_ACK_OFF;
            tswr_pkg::OP_TICK:  state_next = timer_running ? tswr_pkg::S_TICK_ADD
                                                           : tswr_pkg::S_STATUS;
            tswr_pkg::OP_EMPTY: state_next = tswr_pkg::S_EMPTY;
            default:            state_next = tswr_pkg::S_STATUS;
          endcase
        end
      end
      tswr_pkg::S_PUSH_EVAL: begin
        if (push_stop) begin
          state_next = (p_n == '0) ? tswr_pkg::S_STATUS : tswr_pkg::S_EMIT_RD;
        end else begin
          ram_we     = 1'b1;
          state_next = tswr_pkg::S_PUSH_BRT;
        end
      end
      tswr_pkg::S_PUSH_BRT: begin
        alu_op     = '{a: brt, b: 64'(cur_take), sub: 1'b0};
        state_next = tswr_pkg::S_PUSH_NXT;
      end
      tswr_pkg::S_PUSH_NXT: begin
        alu_op     = '{a: next_abs, b: 64'(cur_sl), sub: 1'b0};
        state_next = tswr_pkg::S_PUSH_EVAL;
      end
      tswr_pkg::S_EMPTY: begin
        state_next = tswr_pkg::S_OUT;
      end
      tswr_pkg::S_ACK_OFF: begin
        alu_op     = '{a: {32'b0, ack_q}, b: {32'b0, isn}, sub: 1'b1};
        state_next = tswr_pkg::S_ACK_UNW;
      end
      tswr_pkg::S_ACK_UNW: begin
        alu_op     = '{a: {32'b0, off}, b: {32'b0, brt[31:0]}, sub: 1'b1};
        state_next = tswr_pkg::S_ACK_HI;
      end
      tswr_pkg::S_ACK_HI: begin
        alu_op     = '{a: {32'b0, brt[63:32]}, b: 64'(adj_dec | adj_inc), sub: adj_dec};
        state_next = tswr_pkg::S_ACK_LIM;
      end
      tswr_pkg::S_ACK_LIM: begin
        alu_op     = '{a: acked_abs, b: 64'(fs), sub: 1'b0};
        state_next = tswr_pkg::S_ACK_CHK;
      end
      tswr_pkg::S_ACK_CHK: begin
        alu_op     = '{a: lim, b: abs_ack, sub: 1'b1};
        state_next = alu_carry ? tswr_pkg::S_ACK_NEW : tswr_pkg::S_ACK_END;
      end
      tswr_pkg::S_ACK_NEW: begin
        alu_op     = '{a: abs_ack, b: acked_abs, sub: 1'b1};
        state_next = (alu_carry && alu_sum != '0) ? tswr_pkg::S_ACK_START
                                                   : tswr_pkg::S_ACK_END;
      end
      tswr_pkg::S_ACK_START: begin
        alu_op     = '{a: next_abs, b: 64'(fs), sub: 1'b1};
        state_next = tswr_pkg::S_ACK_DIST;
      end
      tswr_pkg::S_ACK_DIST: begin
        alu_op     = '{a: abs_ack, b: lim, sub: 1'b1};
        state_next = alu_carry ? tswr_pkg::S_POP_RD : tswr_pkg::S_ACK_END;
      end
      tswr_pkg::S_POP_RD: begin
        ram_raddr  = head;
        state_next = (fs == '0 || ring_count == '0) ? tswr_pkg::S_ACK_END
                                                    : tswr_pkg::S_POP_CHK;
      end
      tswr_pkg::S_POP_CHK: begin
        alu_op     = '{a: ack_dist, b: 64'(rd_sl), sub: 1'b1};
        state_next = alu_carry ? tswr_pkg::S_POP_RD : tswr_pkg::S_ACK_END;
      end
      tswr_pkg::S_ACK_END: begin
        state_next = tswr_pkg::S_STATUS;
      end
      tswr_pkg::S_TICK_ADD: begin
        alu_op     = '{a: {32'b0, timer_elapsed}, b: {32'b0, ms_q}, sub: 1'b0};
        state_next = tswr_pkg::S_TICK_CMP;
      end
      tswr_pkg::S_TICK_CMP: begin
        alu_op = '{a: {32'b0, timer_elapsed}, b: {32'b0, cur_timeout}, sub: 1'b1};
        if (alu_carry && ring_count != '0) begin
          state_next = tswr_pkg::S_EMIT_RD;
        end else begin
          state_next = tswr_pkg::S_STATUS;
        end
      end
      tswr_pkg::S_STATUS: begin
        state_next = tswr_pkg::S_OUT;
      end
      tswr_pkg::S_EMIT_RD: begin
        state_next = tswr_pkg::S_EMIT_LD;
      end
      tswr_pkg::S_EMIT_LD: begin
        state_next = tswr_pkg::S_OUT;
      end
      tswr_pkg::S_OUT: begin
        if (out_ready) begin
          state_next = (em_left != '0) ? tswr_pkg::S_EMIT_RD : tswr_pkg::S_IDLE;
        end
      end
      default: state_next = tswr_pkg::S_IDLE;
    endcase
  end

  // Control state: cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      isn           <= '0;
      init_timeout  <= tswr_pkg::TIMEOUT_RESET;
      cur_timeout   <= tswr_pkg::TIMEOUT_RESET;
      next_abs      <= '0;
      acked_abs     <= '0;
      brt           <= '0;
      peer_window   <= 16'd1;
      fs            <= '0;
      timer_running <= 1'b0;
      timer_elapsed <= '0;
      retx_counter  <= '0;
      fin_done      <= 1'b0;
      error_latched <= 1'b0;
      head          <= '0;
      tail          <= '0;
      ring_count    <= '0;
      p_n           <= '0;
      em_left       <= '0;
    end else begin
      // Configuration writes.
      if (cfg_valid) begin
        if (cfg_index == tswr_pkg::CFG_ISN) begin
          isn <= cfg_data;
        end else if (cfg_index == tswr_pkg::CFG_TIMEOUT) begin
          init_timeout <= cfg_data;
          cur_timeout  <= cfg_data;
        end
      end
      unique case (state)
        tswr_pkg::S_IDLE: begin
          p_n <= '0;
          if (in_valid && tswr_pkg::opcode_t'(opcode) == tswr_pkg::OP_ACK) begin
            error_latched <= error_latched | ack_reset;
            peer_window   <= ack_window;
          end
        end
        tswr_pkg::S_PUSH_EVAL: begin
          if (push_stop) begin
            em_left <= p_n;
          end else begin
            tail       <= ptr_inc(tail);
            ring_count <= ring_count + 1'b1;
            fs         <= fs + seg_sl;
            p_n        <= p_n + 1'b1;
            fin_done   <= fin_done | seg_fin;
            if (!timer_running) begin
              timer_running <= 1'b1;
              timer_elapsed <= '0;
            end
          end
        end
        tswr_pkg::S_PUSH_BRT: brt      <= alu_sum;
        tswr_pkg::S_PUSH_NXT: next_abs <= alu_sum;
        tswr_pkg::S_ACK_NEW: begin
          if (alu_carry && alu_sum != '0) begin
            cur_timeout   <= init_timeout;
            timer_elapsed <= '0;
            acked_abs     <= abs_ack;
            retx_counter  <= '0;
          end
        end
        tswr_pkg::S_POP_CHK: begin
          if (alu_carry) begin
            fs         <= fs - rd_sl;
            head       <= ptr_inc(head);
            ring_count <= ring_count - 1'b1;
          end
        end
        tswr_pkg::S_ACK_END: begin
          if (fs == '0) begin
            timer_running <= 1'b0;
          end
        end
        tswr_pkg::S_TICK_ADD: begin
          timer_elapsed <= alu_sum[32] ? '1 : alu_sum[31:0];
        end
        tswr_pkg::S_TICK_CMP: begin
          em_left <= RES_W'(1);
          if (alu_carry) begin
            timer_elapsed <= '0;
            if (peer_window != '0) begin
              if (retx_counter != '1) begin
                retx_counter <= retx_counter + 1'b1;
              end
              cur_timeout <= cur_timeout[31] ? '1 : {cur_timeout[30:0], 1'b0};
            end
          end
        end
        tswr_pkg::S_EMIT_LD: em_left <= em_left - 1'b1;
        tswr_pkg::S_EMPTY,
        tswr_pkg::S_STATUS:  em_left <= '0;
        default: ;
      endcase
    end
  end

  // Working and output registers: no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      tswr_pkg::S_IDLE: begin
        p_avail    <= bytes_available;
        p_consumed <= '0;
        p_closed   <= stream_closed;
        p_err      <= stream_error | error_latched;
        p_last     <= 1'b0;
        ack_q      <= ack_seqno;
        ms_q       <= elapsed_ms;
        em_ptr     <= tail;
        em_retx    <= 1'b0;
      end
      tswr_pkg::S_PUSH_EVAL: begin
        p_consumed <= p_consumed + 32'(take);
        p_last     <= seg_last;
        cur_take   <= take;
        cur_sl     <= seg_sl;
      end
      tswr_pkg::S_EMPTY: begin
        o_valid_seg <= 1'b1;
        o_seq       <= alu_sum[31:0];
        o_len       <= '0;
        o_syn       <= 1'b0;
        o_fin       <= 1'b0;
        o_rst       <= p_err;
        o_retx      <= 1'b0;
        o_last      <= 1'b1;
      end
      tswr_pkg::S_ACK_OFF: off <= alu_sum[31:0];
      tswr_pkg::S_ACK_UNW: begin
        adj_dec <= unw_dec;
        adj_inc <= unw_inc;
      end
      tswr_pkg::S_ACK_HI:    abs_ack  <= {alu_sum[31:0], off};
      tswr_pkg::S_ACK_LIM:   lim      <= alu_sum;
      tswr_pkg::S_ACK_START: lim      <= alu_sum;
      tswr_pkg::S_ACK_DIST:  ack_dist <= alu_sum;
      tswr_pkg::S_POP_CHK: begin
        if (alu_carry) begin
          ack_dist <= alu_sum;
        end
      end
      tswr_pkg::S_TICK_CMP: begin
        em_ptr  <= head;
        em_retx <= 1'b1;
      end
      tswr_pkg::S_STATUS: begin
        o_valid_seg <= 1'b0;
        o_seq       <= '0;
        o_len       <= '0;
        o_syn       <= 1'b0;
        o_fin       <= 1'b0;
        o_rst       <= 1'b0;
        o_retx      <= 1'b0;
        o_last      <= 1'b1;
      end
      tswr_pkg::S_EMIT_LD: begin
        o_valid_seg <= 1'b1;
        o_seq       <= rd_seq;
        o_len       <= 11'(rd_len);
        o_syn       <= rd_syn;
        o_fin       <= rd_fin;
        o_rst       <= rd_rst;
        o_retx      <= em_retx;
        o_last      <= (em_left == RES_W'(1));
        em_ptr      <= ptr_inc(em_ptr);
      end
      default: ;
    endcase
  end

  // Result ports; counters are final once any result is shown.
  always_comb begin
    segment_valid    = o_valid_seg;
    segment_seqno    = o_seq;
    payload_length   = o_len;
    syn_flag         = o_syn;
    fin_flag         = o_fin;
    rst_flag         = o_rst;
    is_retransmit    = o_retx;
    last_result      = o_last;
    in_flight        = fs;
    retransmit_count = retx_counter;
  end

  `TSWR_CHK_IMP(a_ring_bound, clk, rst, 1'b1, ring_count <= QC_W'(QUEUE_DEPTH), "queue overfilled")
  `TSWR_CHK_IMP(a_flight_queued, clk, rst, fs != '0, ring_count != '0, "flight without queue")
  `TSWR_CHK_NXT(a_last_idle, clk, rst, out_valid && out_ready && last_result, in_ready, "not idle")
  `TSWR_CHK_NXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready, "request overlap")

endmodule

`default_nettype wire

>>> rtl/core/tswr_alu.sv
`default_nettype none

// Shared 64-bit adder/subtractor. For a subtract, carry set means a >= b.
module tswr_alu (
  input  tswr_pkg::alu_op_t op,
  output logic [63:0]       sum,
  output logic              carry
);

  logic [64:0] full;

  always_comb begin
    full  = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + 65'(op.sub);
    sum   = full[63:0];
    carry = full[64];
  end

endmodule

`default_nettype wire

>>> rtl/core/tswr_ram.sv
`default_nettype none

// Simple dual-port RAM with registered read.
module tswr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
